// File: rtl/ggpt_pkg.sv
// Shared constants, codes and neighbor offset table for the gradient path tracer.
package ggpt_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int POT_BITS   = 24;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COORD_W    = 6;
  localparam int DIM_W      = 7;
  localparam int STEP_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NBR_CNT    = 8;
  localparam int NBR_W      = $clog2(NBR_CNT + 1);

  // input kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_TRACE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_LOWER   = 2'd1;
  localparam logic [1:0] ST_STEP_LIMIT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNREACHED  = 3'd5;

  typedef logic signed [1:0] offs_t;

  // scan order: dx outer, dy inner, center skipped
  function automatic offs_t nbr_dx(input logic [NBR_W-1:0] k);
    offs_t d;
    case (k)
      4'd0, 4'd1, 4'd2: d = -2'sd1;
      4'd3, 4'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic offs_t nbr_dy(input logic [NBR_W-1:0] k);
    offs_t d;
    case (k)
      4'd0, 4'd3, 4'd5: d = -2'sd1;
      4'd1, 4'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/grid_gradient_path_trace.sv
// Top level: potential store and gradient-descent path sequencer.
//
// Usage:
//   in_*  : items; in_tuser is the kind (load one cell or trace from a goal).
//           A load writes one potential into the store in the beat it is taken.
//   out_* : one beat per path point, goal first; out_tlast marks the final point
//           and out_tuser carries its status (ok, no lower neighbor, step limit).
//   cfg_* : register writes, always ready; write only while no trace is running.
// Sequencing:
//   Loads can be taken back to back while idle. Each move of a trace reads
//   its eight neighbors one after another through the single read port of the
//   potential memory (a decide step, the scan slots and a resolve step). A
//   trace makes up to 63 moves. The input side is held off (in_tready low)
//   for the whole trace.
// Reset: registers return to their defaults and the sequencer idles; the
//   potential memory is not cleared, so every cell a trace visits must be
//   loaded first.
// Stall: one output register holds a point until taken; the sequencer waits
//   on it while it holds a point and out_tready is low, and the scan itself is never disturbed.
module grid_gradient_path_trace
  import ggpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] cell_index, [35:12] cell_potential, [41:36] goal_x, [47:42] goal_y
  input  logic [47:0]           in_tdata,
  // [0] func
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [5:0] point_x, [11:6] point_y, [15:12] zero
  output logic [15:0]           out_tdata,
  output logic                  out_tlast,
  // [1:0] status
  output logic [1:0]            out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_RESOLVE = 3'd3;

  logic [POT_BITS-1:0] mem [DEPTH];
  logic [POT_BITS-1:0] rdata_r;

  logic [DIM_W-1:0]    map_width_r, map_height_r;
  logic [COORD_W-1:0]  start_x_r, start_y_r;
  logic [STEP_W-1:0]   step_limit_r;
  logic [POT_BITS-1:0] unreached_r;

  logic [2:0]          state_r, state_nxt;
  logic [COORD_W-1:0]  cur_x_r, cur_y_r, bx_r, by_r, pend_x_r, pend_y_r;
  logic [STEP_W-1:0]   step_r;
  logic [NBR_W-1:0]    k_r;
  logic [POT_BITS-1:0] best_r;
  logic                found_r, pend_vld_r;

  logic                out_valid_r, out_last_r;
  logic [COORD_W-1:0]  out_x_r, out_y_r;
  logic [1:0]          out_status_r;

  logic                in_acc, load_we, out_free, at_start, limit_hit;
  logic                emit_now, nbr_in_map, cmp_hit;
  logic [DIM_W-1:0]    w_eff, h_eff;
  logic [7:0]          nx8, ny8;
  logic [2*DIM_W-1:0]  row_base;
  logic [ADDR_W-1:0]   raddr;
  logic [COORD_W-1:0]  emit_x, emit_y;
  logic                emit_last;
  logic [1:0]          emit_status;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_we   = in_acc && (in_tuser == FUNC_LOAD);
  assign out_free  = !out_valid_r || out_tready;

  // clamp map size: 0 acts as 1, above max acts as max
  assign w_eff = (map_width_r == '0) ? DIM_W'(1) :
                 (map_width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : map_width_r;
  assign h_eff = (map_height_r == '0) ? DIM_W'(1) :
                 (map_height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : map_height_r;

  assign at_start  = (cur_x_r == start_x_r) && (cur_y_r == start_y_r);
  assign limit_hit = (step_r >= step_limit_r);

  // neighbor address for the current scan slot
  assign nx8 = {2'b00, cur_x_r} + {{6{nbr_dx(k_r)[1]}}, nbr_dx(k_r)};
  assign ny8 = {2'b00, cur_y_r} + {{6{nbr_dy(k_r)[1]}}, nbr_dy(k_r)};
  assign nbr_in_map = !nx8[7] && !ny8[7] && (nx8[DIM_W-1:0] < w_eff)
                      && (ny8[DIM_W-1:0] < h_eff);
  assign row_base = ny8[DIM_W-1:0] * w_eff;
  assign raddr    = row_base[ADDR_W-1:0] + ADDR_W'(nx8[COORD_W-1:0]);

  assign cmp_hit = pend_vld_r && (rdata_r < best_r);

  // what goes into the output register this cycle, if anything
  always_comb begin
    emit_now    = 1'b0;
    emit_x      = cur_x_r;
    emit_y      = cur_y_r;
    emit_last   = 1'b1;
    emit_status = ST_OK;
    case (state_r)
      S_DECIDE: begin
        emit_now    = (at_start || limit_hit) && out_free;
        emit_status = at_start ? ST_OK : ST_STEP_LIMIT;
      end
      S_RESOLVE: begin
        emit_now    = out_free;
        emit_last   = !found_r;
        emit_status = found_r ? ST_OK : ST_NO_LOWER;
      end
      default: emit_now = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == FUNC_TRACE)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (at_start || limit_hit) begin
          if (out_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_r == NBR_W'(NBR_CNT)) state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (out_free) state_nxt = found_r ? S_DECIDE : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // potential store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (load_we) mem[in_tdata[ADDR_W-1:0]] <= in_tdata[35:12];
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= DIM_W'(MAX_WIDTH);
      map_height_r <= DIM_W'(MAX_HEIGHT);
      start_x_r    <= '0;
      start_y_r    <= '0;
      step_limit_r <= STEP_W'(63);
      unreached_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_data[DIM_W-1:0];
        CFG_MAP_HEIGHT: map_height_r <= cfg_data[DIM_W-1:0];
        CFG_START_X:    start_x_r    <= cfg_data[COORD_W-1:0];
        CFG_START_Y:    start_y_r    <= cfg_data[COORD_W-1:0];
        CFG_STEP_LIMIT: step_limit_r <= cfg_data[STEP_W-1:0];
        CFG_UNREACHED:  unreached_r  <= cfg_data[POT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      step_r     <= '0;
      k_r        <= '0;
      found_r    <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= (state_r == S_SCAN) && (k_r != NBR_W'(NBR_CNT)) && nbr_in_map;
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser == FUNC_TRACE)) begin
            cur_x_r <= in_tdata[41:36];
            cur_y_r <= in_tdata[47:42];
            step_r  <= '0;
          end
        end
        S_DECIDE: begin
          k_r     <= '0;
          found_r <= 1'b0;
        end
        S_SCAN: begin
          k_r <= k_r + NBR_W'(1);
          if (cmp_hit) found_r <= 1'b1;
        end
        S_RESOLVE: begin
          if (out_free && found_r) begin
            cur_x_r <= bx_r;
            cur_y_r <= by_r;
            step_r  <= step_r + STEP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // scan datapath: address of the pending read and running minimum
  always_ff @(posedge clk) begin
    pend_x_r <= nx8[COORD_W-1:0];
    pend_y_r <= ny8[COORD_W-1:0];
    if (state_r == S_DECIDE) begin
      best_r <= unreached_r;
    end else if (state_r == S_SCAN && cmp_hit) begin
      best_r <= rdata_r;
      bx_r   <= pend_x_r;
      by_r   <= pend_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_now) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_x_r      <= emit_x;
      out_y_r      <= emit_y;
      out_last_r   <= emit_last;
      out_status_r <= emit_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

// File: rtl/ggpt_checker.sv
// Port-level checker for the gradient path tracer, bound to the top level.
module ggpt_checker
  import ggpt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // a failure status only ever rides on the final point
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tlast)
    else $error("nonzero status on a non-final point");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NO_LOWER ||
                    out_tuser == ST_STEP_LIMIT))
    else $error("undefined status code");

  // a trace beat closes the input: in_tready drops once the beat is taken
  a_trace_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_TRACE) |=> !in_tready)
    else $error("input taken right after a trace beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

endmodule

bind grid_gradient_path_trace ggpt_checker u_ggpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
